FILE: rtl/core/jrv_pkg.sv
// Shared types and character constants for the JSON reindenting validator.
`timescale 1ns / 1ps
package jrv_pkg;

  // Width of the nesting depth and of an indentation count.
  localparam int LVL_W = 6;
  // Width of the beat position counter inside one command.
  localparam int POS_W = LVL_W + 1;
  // Depth of the command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [15:0] CH_LBRACE    = 16'h007B;
  localparam logic [15:0] CH_LBRACKET  = 16'h005B;
  localparam logic [15:0] CH_RBRACE    = 16'h007D;
  localparam logic [15:0] CH_RBRACKET  = 16'h005D;
  localparam logic [15:0] CH_COMMA     = 16'h002C;
  localparam logic [15:0] CH_QUOTE     = 16'h0022;
  localparam logic [15:0] CH_BACKSLASH = 16'h005C;
  localparam logic [15:0] CH_NEWLINE   = 16'h000A;
  localparam logic [15:0] CH_SPACE     = 16'h0020;

  // How the back end expands one character.
  typedef enum logic [1:0] {
    CMD_PLAIN = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_COMMA = 2'd3
  } cmd_kind_t;

  // One classified character on its way to the back end.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [15:0]        ch;
    logic [LVL_W-1:0]   indent;
    logic               fin;
    logic               ok;
  } cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

FILE: rtl/core/jrv_front.sv
// Front end: classifies each character and tracks depth, string and error state.
`timescale 1ns / 1ps
module jrv_front #(
  parameter int MAX_NEST = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [15:0]       text_char,
  input  logic              final_char,
  output jrv_pkg::cmd_t     cmd
);
  import jrv_pkg::*;

  localparam logic [LVL_W-1:0] MaxLvl = LVL_W'(MAX_NEST);

  logic [LVL_W-1:0] nest_r, nest_nxt;
  logic             instr_r, instr_nxt;
  logic             esc_r, esc_nxt;
  logic             err_r, err_nxt;
  cmd_kind_t        kind;

  // Classify the character and work out the next state.
  always_comb begin
    nest_nxt  = nest_r;
    instr_nxt = instr_r;
    esc_nxt   = esc_r;
    err_nxt   = err_r;
    kind      = CMD_PLAIN;
    if (instr_r) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (text_char == CH_BACKSLASH) begin
        esc_nxt = 1'b1;
      end else if (text_char == CH_QUOTE) begin
        instr_nxt = 1'b0;
      end
    end else if (text_char == CH_QUOTE) begin
      instr_nxt = 1'b1;
    end else if (text_char inside {CH_LBRACE, CH_LBRACKET}) begin
      kind = CMD_OPEN;
      if (nest_r >= MaxLvl) begin
        err_nxt  = 1'b1;
        nest_nxt = MaxLvl;
      end else begin
        nest_nxt = nest_r + 1'b1;
      end
    end else if (text_char inside {CH_RBRACE, CH_RBRACKET}) begin
      kind = CMD_CLOSE;
      if (nest_r == '0) begin
        err_nxt = 1'b1;
      end else begin
        nest_nxt = nest_r - 1'b1;
      end
    end else if (text_char == CH_COMMA) begin
      kind = CMD_COMMA;
    end
  end

  assign cmd.kind   = kind;
  assign cmd.ch     = text_char;
  assign cmd.indent = nest_nxt;
  assign cmd.fin    = final_char;
  assign cmd.ok     = !err_nxt && !instr_nxt && (nest_nxt == '0);

  // State update; the final character starts a fresh text.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nest_r  <= '0;
      instr_r <= 1'b0;
      esc_r   <= 1'b0;
      err_r   <= 1'b0;
    end else if (accept) begin
      if (final_char) begin
        nest_r  <= '0;
        instr_r <= 1'b0;
        esc_r   <= 1'b0;
        err_r   <= 1'b0;
      end else begin
        nest_r  <= nest_nxt;
        instr_r <= instr_nxt;
        esc_r   <= esc_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/jrv_cmdq.sv
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module jrv_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  jrv_pkg::cmd_t     wr_cmd,
  input  logic              rd_pop,
  output jrv_pkg::cmd_t     rd_cmd,
  output jrv_pkg::q_stat_t  stat
);
  import jrv_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_wr, do_rd;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.valid = (cnt_r != '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_pop && stat.valid;
  assign rd_cmd     = slot_r[rptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= wr_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/jrv_back.sv
// Back end: expands each command into output beats held in an output register.
`timescale 1ns / 1ps
module jrv_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jrv_pkg::cmd_t     cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output logic [15:0]       out_char,
  output logic              out_run_end,
  output logic              out_text_end,
  output logic              out_structure_ok
);
  import jrv_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic             oval_r;
  logic [15:0]      och_r;
  logic             orun_r, otext_r, ook_r;
  logic             last;
  logic             advance;
  logic [15:0]      beat_ch;

  // Last beat of the current command.
  always_comb begin
    if (cmd.kind == CMD_PLAIN) begin
      last = (pos_r == '0);
    end else begin
      last = (pos_r == ({1'b0, cmd.indent} + POS_W'(1)));
    end
  end

  // Character for the current beat position.
  always_comb begin
    case (cmd.kind)
      CMD_PLAIN: beat_ch = cmd.ch;
      CMD_OPEN, CMD_COMMA: begin
        if (pos_r == '0) begin
          beat_ch = cmd.ch;
        end else if (pos_r == POS_W'(1)) begin
          beat_ch = CH_NEWLINE;
        end else begin
          beat_ch = CH_SPACE;
        end
      end
      CMD_CLOSE: begin
        if (pos_r == '0) begin
          beat_ch = CH_NEWLINE;
        end else if (last) begin
          beat_ch = cmd.ch;
        end else begin
          beat_ch = CH_SPACE;
        end
      end
      default: beat_ch = cmd.ch;
    endcase
  end

  assign advance = cmd_valid && (!oval_r || pop);
  assign cmd_pop = advance && last;

  // Beat position within the current command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (advance) begin
      pos_r <= last ? '0 : pos_r + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (advance) begin
      oval_r <= 1'b1;
    end else if (pop) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      och_r   <= beat_ch;
      orun_r  <= last;
      otext_r <= last && cmd.fin;
      ook_r   <= last && cmd.fin && cmd.ok;
    end
  end

  assign empty            = !oval_r;
  assign out_char         = och_r;
  assign out_run_end      = orun_r;
  assign out_text_end     = otext_r;
  assign out_structure_ok = ook_r;

endmodule

FILE: rtl/core/json_reindent_validate.sv
// Top level of the streaming JSON reindenter with bracket and string check.
`timescale 1ns / 1ps
// One 16-bit character enters per beat on push/full; results leave on
// empty/pop, one code unit per beat. The front end classifies a character
// in the cycle it is accepted and parks it in a four-entry command queue,
// so input keeps flowing while the back end is busy, until the queue fills.
// The back end emits one result beat per cycle when its output register is
// free or popped: a plain character is one beat, a comma or opening bracket
// two beats plus one per indentation space, a closing bracket likewise, so
// sustained throughput is set by the back end's output beats (up to
// MAX_NEST + 2 per character). The last beat of a text carries text_end and
// the structure verdict; the next character starts a new text at depth zero.
module json_reindent_validate #(
  parameter int MAX_NEST = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_text_char,
  input  logic        in_final_char,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_char,
  output logic        out_run_end,
  output logic        out_text_end,
  output logic        out_structure_ok
);
  import jrv_pkg::*;

  cmd_t    f_cmd;
  cmd_t    q_cmd;
  q_stat_t q_stat;
  logic    accept;
  logic    q_pop;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  // Classification and state tracking.
  jrv_front #(
    .MAX_NEST (MAX_NEST)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .text_char  (in_text_char),
    .final_char (in_final_char),
    .cmd        (f_cmd)
  );

  // Decoupling queue.
  jrv_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .wr_cmd (f_cmd),
    .rd_pop (q_pop),
    .rd_cmd (q_cmd),
    .stat   (q_stat)
  );

  // Beat expansion and output register.
  jrv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (q_cmd),
    .cmd_valid        (q_stat.valid),
    .cmd_pop          (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_char         (out_char),
    .out_run_end      (out_run_end),
    .out_text_end     (out_text_end),
    .out_structure_ok (out_structure_ok)
  );

endmodule
